@@ src/laplacian_edge_filter_3x3_top_macros.svh @@
// Assertion macros for the checker file of the edge filter.
`ifndef LAPLACIAN_EDGE_FILTER_3X3_TOP_MACROS_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_TOP_MACROS_SVH

// Check a property at every clock edge outside of reset.
`define LEF_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("edge filter check failed");

// Check a property at every clock edge, reset included.
`define LEF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("edge filter check failed");

`endif

@@ src/lef_pkg.sv @@
// Shared constants, register codes and payload types of the Laplacian edge filter.
`timescale 1ns / 1ps
`default_nettype none
package lef_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  // Field and counter widths
  localparam int PIX_W     = 8;
  localparam int WEIGHT_W  = 8;
  localparam int WID_W     = 11;
  localparam int HGT_W     = 13;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int NSUM_W    = PIX_W + 3;
  localparam int PROD_W    = WEIGHT_W + PIX_W + 1;
  localparam int TOTAL_W   = PROD_W + 1;

  // Line memory entry: red of the line two rows back over RGB of the previous line
  localparam int LINE_W = 4 * PIX_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd8;
  localparam logic [WID_W-1:0]    WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0]    HEIGHT_RESET = 13'd480;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_WEIGHT = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_end;
  } result_t;

  // One column of the 3x3 red window
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

endpackage
`default_nettype wire

@@ src/lef_pixel_if.sv @@
// Valid/ready channel that carries input pixels and flush ticks.
`timescale 1ns / 1ps
`default_nettype none
interface lef_pixel_if;
  import lef_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/lef_result_if.sv @@
// Valid/ready channel that carries filtered result pixels.
`timescale 1ns / 1ps
`default_nettype none
interface lef_result_if;
  import lef_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/lef_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data shows the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/lef_out_queue.sv @@
// Result queue that decouples the filter pipeline from the output handshake.
`timescale 1ns / 1ps
`default_nettype none
module lef_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lef_pkg::result_t  push_data,
  lef_result_if.source      res
);
  import lef_pkg::*;

  result_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign pop       = res.valid && res.ready;
  assign res.valid = (count != '0);
  assign res.data  = slots[rd_ptr];

  // Store pushed results; the credit check upstream keeps the queue from overflowing
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/laplacian_edge_filter_3x3_top.sv @@
// Top level of the streaming 3x3 Laplacian edge filter.
`timescale 1ns / 1ps
`default_nettype none
// The filter takes one pixel or flush tick per clock and sustains one item per cycle,
// except while the input stalls. Each item that is not dropped reads and rewrites
// one entry of a single line memory (red of the line two rows back beside RGB of the
// previous line), so the memory's one read and one write port per cycle set that
// rate. A result goes from the transfer through the memory read, window shift,
// product and neighbor sum, then magnitude and saturation into the queue write, and
// can leave the queue in the cycle after that write. The input stalls only while
// eight results are outstanding. Results lag the input by one line plus one pixel;
// after the last pixel of a frame, send image_width + 1 flush ticks to drain it. The
// line memory needs no clearing pass after reset: entries read before the first two
// rows of a frame rewrite them feed only first-row outputs, which pass the pixel through.
// Writing image_width or image_height restarts the frame; write configuration only
// while the block is idle.
module laplacian_edge_filter_3x3_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data,
  lef_pixel_if.sink                      pix,
  lef_result_if.source                   res
);
  import lef_pkg::*;

  // Configuration registers
  logic signed [WEIGHT_W-1:0] center_weight;
  logic [WID_W-1:0]           image_width;
  logic [HGT_W-1:0]           image_height;
  logic                       geom_write;

  // Raster position counters
  logic [COL_W-1:0]     in_col, in_col_next;
  logic [IN_ROW_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]     out_col, out_col_next;
  logic [OUT_ROW_W-1:0] out_row, out_row_next;

  // Stage 0 decode
  logic [WID_W-1:0]     w_eff;
  logic [HGT_W-1:0]     h_eff;
  logic [COL_W-1:0]     w_last;
  logic [OUT_ROW_W-1:0] h_last;
  logic                 pix_xfer;
  logic                 is_flush;
  logic                 in_done;
  logic                 take;
  logic                 produce;
  logic                 emit;
  logic                 border;
  logic                 last;

  // Outstanding result credits
  logic [QCNT_W-1:0] pending;
  logic              res_xfer;

  // Stage 1: line memory response
  logic                 s1_valid;
  logic                 s1_emit;
  logic [COL_W-1:0]     s1_col;
  logic [3*PIX_W-1:0]   s1_pix;
  logic                 s1_border;
  logic                 s1_last;
  logic [LINE_W-1:0]    ram_q;
  logic [LINE_W-1:0]    line;
  logic [LINE_W-1:0]    line_wdata;
  logic                 byp_hit;
  logic [LINE_W-1:0]    byp_data;

  // Window state
  win_col_t         win_a, win_b, win_c;
  logic [PIX_W-1:0] grn0, grn1, blu0, blu1;

  // Stage 2: window is current
  logic                  s2_valid;
  logic                  s2_border;
  logic                  s2_last;
  logic signed [PROD_W-1:0] prod_c;
  logic [NSUM_W-1:0]     nsum_c;

  // Stage 3: magnitude
  logic                     s3_valid;
  logic                     s3_border;
  logic                     s3_last;
  logic signed [PROD_W-1:0] s3_prod;
  logic [NSUM_W-1:0]        s3_nsum;
  logic [PIX_W-1:0]         s3_center;
  logic [PIX_W-1:0]         s3_grn;
  logic [PIX_W-1:0]         s3_blu;
  logic signed [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0]       mag;
  logic [PIX_W-1:0]         sat;
  result_t                  push_data;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_weight <= WEIGHT_RESET;
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_WEIGHT: center_weight <= cfg_data[WEIGHT_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[HGT_W-1:0];
        default:           center_weight <= center_weight;
      endcase
    end
  end

  assign geom_write = cfg_write &&
                      (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // Clamp geometry to the supported range
  assign w_eff = (image_width < WID_W'(MIN_WIDTH)) ? WID_W'(MIN_WIDTH) :
                 (image_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : image_width;
  assign h_eff = (image_height < HGT_W'(MIN_HEIGHT)) ? HGT_W'(MIN_HEIGHT) :
                 (image_height > HGT_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : image_height;
  assign w_last = COL_W'(w_eff - 1'b1);
  assign h_last = OUT_ROW_W'(h_eff - 1'b1);

  // Decode the incoming item: drop pixels after the frame and flushes before its end
  assign res_xfer  = res.valid && res.ready;
  assign pix.ready = !pending[QCNT_W-1];
  assign pix_xfer  = pix.valid && pix.ready;
  assign is_flush  = (pix.data.action == ACT_FLUSH);
  assign in_done   = (IN_ROW_W'(h_eff) <= in_row);
  assign take      = pix_xfer && (is_flush == in_done);
  assign produce   = is_flush || (in_row > IN_ROW_W'(1)) ||
                     ((in_row == IN_ROW_W'(1)) && (in_col != '0));
  assign emit      = take && produce;
  assign border    = (out_row == '0) || (out_col == '0) || (out_col == w_last);
  assign last      = (out_row == h_last) && (out_col == w_last);

  // Advance raster counters
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (geom_write) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (take) begin
      if (in_col == w_last) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
      if (emit) begin
        if (out_col == w_last) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
        if (last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Count results accepted but not yet transferred out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({emit, res_xfer})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // Line memory: read at the input column, write back in the following cycle
  lef_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (line_wdata),
    .raddr (in_col),
    .rdata (ram_q)
  );

  // Register stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= take;
      byp_hit  <= take && s1_valid && (s1_col == in_col);
    end
  end

  always_ff @(posedge clk) begin
    s1_emit   <= emit;
    s1_col    <= in_col;
    s1_border <= border;
    s1_last   <= last;
    byp_data  <= line_wdata;
    if (is_flush) begin
      s1_pix <= '0;
    end else begin
      s1_pix <= {pix.data.blue_in, pix.data.green_in, pix.data.red_in};
    end
  end

  // Forward a write that lands on the entry read in the same cycle
  assign line       = byp_hit ? byp_data : ram_q;
  assign line_wdata = {line[PIX_W-1:0], s1_pix};

  // Shift the new column into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
      win_c <= '0;
      grn0  <= '0;
      grn1  <= '0;
      blu0  <= '0;
      blu1  <= '0;
    end else if (s1_valid) begin
      win_a    <= win_b;
      win_b    <= win_c;
      win_c.top <= line[4*PIX_W-1:3*PIX_W];
      win_c.mid <= line[PIX_W-1:0];
      win_c.bot <= s1_pix[PIX_W-1:0];
      grn0     <= grn1;
      blu0     <= blu1;
      grn1     <= line[2*PIX_W-1:PIX_W];
      blu1     <= line[3*PIX_W-1:2*PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_border <= s1_border;
    s2_last   <= s1_last;
  end

  // Weight the center and sum the eight neighbors
  assign prod_c = PROD_W'(center_weight) * PROD_W'($signed({1'b0, win_b.mid}));
  assign nsum_c = NSUM_W'(win_a.top) + NSUM_W'(win_a.mid) + NSUM_W'(win_a.bot) +
                  NSUM_W'(win_b.top) + NSUM_W'(win_b.bot) +
                  NSUM_W'(win_c.top) + NSUM_W'(win_c.mid) + NSUM_W'(win_c.bot);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod   <= prod_c;
    s3_nsum   <= nsum_c;
    s3_center <= win_b.mid;
    s3_grn    <= grn0;
    s3_blu    <= blu0;
    s3_border <= s2_border;
    s3_last   <= s2_last;
  end

  // Take the magnitude and saturate to eight bits
  assign total = $signed({s3_prod[PROD_W-1], s3_prod}) -
                 $signed({{(TOTAL_W-NSUM_W){1'b0}}, s3_nsum});
  assign mag   = total[TOTAL_W-1] ? (~total + 1'b1) : total;
  assign sat   = (mag > TOTAL_W'(255)) ? {PIX_W{1'b1}} : mag[PIX_W-1:0];

  // Pick pass-through on the border, edge magnitude inside
  always_comb begin
    if (s3_border) begin
      push_data.red_out   = s3_center;
      push_data.green_out = s3_grn;
      push_data.blue_out  = s3_blu;
    end else begin
      push_data.red_out   = sat;
      push_data.green_out = sat;
      push_data.blue_out  = sat;
    end
    push_data.frame_end = s3_last;
  end

  lef_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid),
    .push_data (push_data),
    .res       (res)
  );

endmodule
`default_nettype wire

@@ src/lef_checker.sv @@
// Port-level checks of the edge filter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "laplacian_edge_filter_3x3_top_macros.svh"
module lef_checker (
  input logic             clk,
  input logic             rst,
  input logic             pix_ready,
  input logic             res_valid,
  input logic             res_ready,
  input lef_pkg::result_t res_data
);
  import lef_pkg::*;

  // A stalled result stays offered
  `LEF_ASSERT_RUN(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid)

  // A stalled result keeps its payload
  `LEF_ASSERT_RUN(a_res_stable, clk, rst, res_valid && !res_ready |=> $stable(res_data))

  // Input back-pressure only while results wait at the output
  `LEF_ASSERT_RUN(a_stall_has_result, clk, rst, !pix_ready |-> res_valid)

  // Reset empties the result queue
  `LEF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid)

endmodule

bind laplacian_edge_filter_3x3_top lef_checker u_lef_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
`default_nettype wire
